// File: design/dtpd_pkg.sv
`timescale 1ns / 1ps
package dtpd_pkg;

  // default sizes
  localparam int unsigned ClickCountDef = 3;
  localparam int unsigned TimeWidthDef  = 32;

  // fixed field widths
  localparam int unsigned NowW   = 32;
  localparam int unsigned TickW  = 32;
  localparam int unsigned PulseW = 16;
  localparam int unsigned CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounce    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgClickWindow = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHoldTicks   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPulseRecent = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPulseIdle   = 3'd4;

  // register reset values
  localparam logic [TickW-1:0]  DebounceRst    = 32'd125;
  localparam logic [TickW-1:0]  ClickWindowRst = 32'd31250;
  localparam logic [TickW-1:0]  HoldTicksRst   = 32'd125000;
  localparam logic [PulseW-1:0] PulseRecentRst = 16'd1000;
  localparam logic [PulseW-1:0] PulseIdleRst   = 16'd5000;

  // register file contents
  typedef struct packed {
    logic [TickW-1:0]  debounce_ticks;
    logic [TickW-1:0]  click_window;
    logic [TickW-1:0]  hold_ticks;
    logic [PulseW-1:0] pulse_recent;
    logic [PulseW-1:0] pulse_idle;
  } cfg_t;

endpackage

// File: design/debounced_triple_press_detector_top.sv
`timescale 1ns / 1ps
// Debounced triple-press detector with servo pulse select.
// Input channel (in_valid_i / in_ready_o) carries one word per time sample:
// the current timer time and a flag for a button edge captured at that time.
// Output channel (out_valid_o / out_ready_i) returns one word per input word:
// the selected servo pulse value and the triple-click-recent flag.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes one register per
// word by index; it is always ready. The user must see that it is written
// only while the block idles; the block itself does not enforce this.
// A word passes the debounce and press chain at the accepting edge, the
// click window test and the hold test into the output register. Throughput:
// one word per cycle unless the receiver stalls, set by the press chain and
// the debounce timestamp. A stalled receiver holds the output register; the
// two inner stages still fill, so up to three words are in flight before
// in_ready_o drops. Reset clears the press chain, the phase, the timestamps
// and all valid flags, and loads the register defaults.
module debounced_triple_press_detector_top #(
  parameter int unsigned CLICK_COUNT = dtpd_pkg::ClickCountDef,
  parameter int unsigned TIME_WIDTH  = dtpd_pkg::TimeWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dtpd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dtpd_pkg::TickW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dtpd_pkg::NowW-1:0]    now_ticks_i,
  input  logic                         edge_seen_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dtpd_pkg::PulseW-1:0]  servo_pulse_o,
  output logic                         triple_recent_o
);
  import dtpd_pkg::*;

  localparam int unsigned CmpW = (TIME_WIDTH > TickW) ? TIME_WIDTH : TickW;

  cfg_t cfg;

  dtpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake across the three stages
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_ready, s2_ready, s3_ready;
  logic in_fire, s1_move, s2_move;

  assign s3_ready   = !out_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;
  assign s1_move    = s1_valid_q && s2_ready;
  assign s2_move    = s2_valid_q && s3_ready;

  // debounce and press phase
  logic [TIME_WIDTH-1:0] now_in;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic                  phase_q, phase_d;
  logic [TIME_WIDTH-1:0] since_last;
  logic                  edge_ok;
  logic                  press_shift;

  assign now_in      = TIME_WIDTH'(now_ticks_i);
  assign since_last  = now_in - last_q;
  assign edge_ok     = in_fire && edge_seen_i &&
                       (CmpW'(since_last) > CmpW'(cfg.debounce_ticks));
  assign press_shift = edge_ok && !phase_q;
  assign last_d      = edge_ok ? now_in : last_q;
  assign phase_d     = edge_ok ? !phase_q : phase_q;

  // press time chain, cell 0 newest, last cell oldest
  logic [TIME_WIDTH-1:0] press_q [CLICK_COUNT];

  for (genvar g = 0; g < CLICK_COUNT; g++) begin : g_cell
    logic [TIME_WIDTH-1:0] cell_in;
    if (g == 0) begin : g_head
      assign cell_in = now_in;
    end else begin : g_body
      assign cell_in = press_q[g-1];
    end
    dtpd_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (press_shift),
      .time_i  (cell_in),
      .time_o  (press_q[g])
    );
  end

  // click window test on the chain left by the stage 1 word
  logic [TIME_WIDTH-1:0] s1_now_q, s1_now_d;
  logic [TIME_WIDTH-1:0] span;
  logic [TIME_WIDTH-1:0] triple_q, triple_d;
  logic                  in_window;

  assign span      = press_q[0] - press_q[CLICK_COUNT-1];
  assign in_window = CmpW'(span) < CmpW'(cfg.click_window);
  assign triple_d  = (s1_move && in_window) ? press_q[0] : triple_q;
  assign s1_now_d  = in_fire ? now_in : s1_now_q;
  assign s1_valid_d = in_fire ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_q);

  // hold test into the output register
  logic [TIME_WIDTH-1:0] s2_now_q, s2_now_d;
  logic [TIME_WIDTH-1:0] since_triple;
  logic                  recent;
  logic [PulseW-1:0]     pulse_q, pulse_d;
  logic                  recent_q, recent_d;

  assign s2_now_d     = s1_move ? s1_now_q : s2_now_q;
  assign s2_valid_d   = s2_ready ? s1_valid_q : s2_valid_q;
  assign since_triple = s2_now_q - triple_q;
  assign recent       = CmpW'(since_triple) <= CmpW'(cfg.hold_ticks);
  assign out_valid_d  = s3_ready ? s2_valid_q : out_valid_q;
  assign recent_d     = s2_move ? recent : recent_q;
  assign pulse_d      = s2_move ? (recent ? cfg.pulse_recent : cfg.pulse_idle) : pulse_q;

  // control and timestamps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      phase_q     <= 1'b0;
      triple_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      phase_q     <= phase_d;
      triple_q    <= triple_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    s1_now_q <= s1_now_d;
    s2_now_q <= s2_now_d;
    pulse_q  <= pulse_d;
    recent_q <= recent_d;
  end

  assign out_valid_o     = out_valid_q;
  assign servo_pulse_o   = pulse_q;
  assign triple_recent_o = recent_q;

endmodule

// File: design/dtpd_cfg.sv
`timescale 1ns / 1ps
module dtpd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dtpd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dtpd_pkg::TickW-1:0]   cfg_data_i,
  output dtpd_pkg::cfg_t               cfg_o
);
  import dtpd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDebounce:    cfg_d.debounce_ticks = cfg_data_i;
        CfgClickWindow: cfg_d.click_window   = cfg_data_i;
        CfgHoldTicks:   cfg_d.hold_ticks     = cfg_data_i;
        CfgPulseRecent: cfg_d.pulse_recent   = cfg_data_i[PulseW-1:0];
        CfgPulseIdle:   cfg_d.pulse_idle     = cfg_data_i[PulseW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DebounceRst;
      cfg_q.click_window   <= ClickWindowRst;
      cfg_q.hold_ticks     <= HoldTicksRst;
      cfg_q.pulse_recent   <= PulseRecentRst;
      cfg_q.pulse_idle     <= PulseIdleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/dtpd_cell.sv
`timescale 1ns / 1ps
module dtpd_cell #(
  parameter int unsigned TIME_WIDTH = dtpd_pkg::TimeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic [TIME_WIDTH-1:0] time_i,
  output logic [TIME_WIDTH-1:0] time_o
);
  import dtpd_pkg::*;

  logic [TIME_WIDTH-1:0] time_q;
  logic [TIME_WIDTH-1:0] time_d;

  // take the neighbor's press time on a new press
  assign time_d = shift_i ? time_i : time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else begin
      time_q <= time_d;
    end
  end

  assign time_o = time_q;

endmodule

// File: sim/dtpd_pulse_checker.sv
`timescale 1ns / 1ps
module dtpd_pulse_checker
  import dtpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [NowW-1:0]   now_ticks_i,
  input  logic              edge_seen_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [PulseW-1:0] servo_pulse_i,
  input  logic              triple_recent_i,
  output int                pending_o,
  output int                mismatch_count_o
);

  localparam int unsigned RingDepth = ClickCountDef;

  typedef struct packed {
    logic [PulseW-1:0] servo_pulse;
    logic              triple_recent;
  } pulse_word_t;

  // shadow registers and detector state
  cfg_t              regs;
  logic [NowW-1:0]   accepted_at;
  logic              in_press;
  logic [NowW-1:0]   press_ring [RingDepth];
  int unsigned       ring_slot;
  logic [NowW-1:0]   triple_at;
  pulse_word_t       pulse_expected_q[$];

  initial begin
    pending_o = 0;
    mismatch_count_o = 0;
  end

  // debounce, press ring, triple test and hold test for one time sample
  function automatic pulse_word_t predict_pulse(logic [NowW-1:0] now, logic with_edge);
    pulse_word_t     word;
    logic [NowW-1:0] oldest;
    logic [NowW-1:0] newest;
    logic            held;
    if (with_edge && (now - accepted_at) > regs.debounce_ticks) begin
      accepted_at = now;
      if (!in_press) begin
        in_press = 1'b1;
        press_ring[ring_slot] = now;
        ring_slot = (ring_slot + 1) % RingDepth;
      end else begin
        in_press = 1'b0;
      end
    end
    oldest = press_ring[ring_slot];
    newest = press_ring[(ring_slot + RingDepth - 1) % RingDepth];
    if ((newest - oldest) < regs.click_window) begin
      triple_at = newest;
    end
    held = (now - triple_at) <= regs.hold_ticks;
    word.servo_pulse = held ? regs.pulse_recent : regs.pulse_idle;
    word.triple_recent = held;
    return word;
  endfunction

  task automatic flag_mismatch(input string what, input pulse_word_t want);
    if (mismatch_count_o < 10) begin
      $display("%0t: %s: expected pulse %0d recent %0b, got pulse %0d recent %0b",
               $realtime, what, want.servo_pulse, want.triple_recent,
               servo_pulse_i, triple_recent_i);
    end
    mismatch_count_o++;
  endtask

  // watch the three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    pulse_word_t want;
    if (!rst_ni) begin
      regs = '{debounce_ticks: DebounceRst, click_window: ClickWindowRst,
               hold_ticks: HoldTicksRst, pulse_recent: PulseRecentRst,
               pulse_idle: PulseIdleRst};
      accepted_at = '0;
      in_press = 1'b0;
      for (int i = 0; i < RingDepth; i++) press_ring[i] = '0;
      ring_slot = 0;
      triple_at = '0;
      pulse_expected_q.delete();
      pending_o = 0;
    end else begin
      // result word against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (pulse_expected_q.size() == 0) begin
          want = '0;
          flag_mismatch("result word with nothing expected", want);
        end else begin
          want = pulse_expected_q.pop_front();
          if (servo_pulse_i !== want.servo_pulse || triple_recent_i !== want.triple_recent) begin
            flag_mismatch("result word mismatch", want);
          end
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDebounce:    regs.debounce_ticks = cfg_data_i;
          CfgClickWindow: regs.click_window = cfg_data_i;
          CfgHoldTicks:   regs.hold_ticks = cfg_data_i;
          CfgPulseRecent: regs.pulse_recent = cfg_data_i[PulseW-1:0];
          CfgPulseIdle:   regs.pulse_idle = cfg_data_i[PulseW-1:0];
          default: ;
        endcase
      end
      // time sample word
      if (in_valid_i && in_ready_i) begin
        pulse_expected_q.push_back(predict_pulse(now_ticks_i, edge_seen_i));
      end
      pending_o = pulse_expected_q.size();
    end
  end

endmodule

// File: sim/debounced_triple_press_detector_top_tb.sv
`timescale 1ns / 1ps
module debounced_triple_press_detector_top_tb
  import dtpd_pkg::*;
;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_r = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_r = '0;
  logic [TickW-1:0]   cfg_data_r = '0;
  logic               in_valid_r = 1'b0;
  logic               in_ready_o;
  logic [NowW-1:0]    now_ticks_r = '0;
  logic               edge_seen_r = 1'b0;
  logic               out_valid_o;
  logic               out_ready_r = 1'b0;
  logic [PulseW-1:0]  servo_pulse_o;
  logic               triple_recent_o;

  int                 pending;
  int                 mismatches;
  int unsigned        sample_count = 0;
  bit                 calm = 1'b0;
  logic [NowW-1:0]    t_now = '0;
  logic [TickW-1:0]   deb_c = DebounceRst;
  logic [TickW-1:0]   win_c = ClickWindowRst;
  logic [TickW-1:0]   hold_c = HoldTicksRst;

  debounced_triple_press_detector_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_r),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_r),
    .cfg_data_i     (cfg_data_r),
    .in_valid_i     (in_valid_r),
    .in_ready_o     (in_ready_o),
    .now_ticks_i    (now_ticks_r),
    .edge_seen_i    (edge_seen_r),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_r),
    .servo_pulse_o  (servo_pulse_o),
    .triple_recent_o(triple_recent_o)
  );

  dtpd_pulse_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_r),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_r),
    .cfg_data_i      (cfg_data_r),
    .in_valid_i      (in_valid_r),
    .in_ready_i      (in_ready_o),
    .now_ticks_i     (now_ticks_r),
    .edge_seen_i     (edge_seen_r),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_r),
    .servo_pulse_i   (servo_pulse_o),
    .triple_recent_i (triple_recent_o),
    .pending_o       (pending),
    .mismatch_count_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("debounced_triple_press_detector_top regression: fail");
    $finish;
  end

  // receiver: random stall before each result word
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ready_r <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_r <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // one time sample word, called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic [NowW-1:0] now, input logic with_edge);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_r <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_r <= 1'b1;
    now_ticks_r <= now;
    edge_seen_r <= with_edge;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sample_count++;
  endtask

  task automatic step_send(input logic [NowW-1:0] dt, input logic with_edge);
    t_now = t_now + dt;
    send_sample(t_now, with_edge);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
    cfg_valid_r <= 1'b1;
    cfg_index_r <= idx;
    cfg_data_r <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // all five registers plus one write to an unused index
  task automatic apply_settings(input logic [TickW-1:0] deb, input logic [TickW-1:0] win,
                                input logic [TickW-1:0] hold, input logic [PulseW-1:0] recent,
                                input logic [PulseW-1:0] idle);
    write_reg(CfgDebounce, deb);
    write_reg(CfgClickWindow, win);
    write_reg(CfgHoldTicks, hold);
    write_reg(CfgPulseRecent, {16'($urandom), recent});
    write_reg(CfgPulseIdle, {16'($urandom), idle});
    write_reg(CfgIdxW'($urandom_range(CfgPulseIdle + 1, (1 << CfgIdxW) - 1)), $urandom);
    cfg_valid_r <= 1'b0;
    deb_c = deb;
    win_c = win;
    hold_c = hold;
  endtask

  task automatic drain;
    in_valid_r <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // spacing to the next edge: mostly just past the debounce, sometimes a slow click
  function automatic logic [NowW-1:0] edge_step();
    if ($urandom_range(0, 3) == 0) begin
      return win_c / 2 + $urandom_range(0, win_c / 2 + 1);
    end
    return deb_c + 1 + $urandom_range(0, (deb_c > 2000) ? 1000 : deb_c / 2 + 20);
  endfunction

  // random press sequences, quiet stretches, bounce storms, noise and wrap
  task automatic run_traffic(input int unsigned count);
    int unsigned target;
    int          kind;
    target = sample_count + count;
    while (sample_count < target) begin
      kind = $urandom_range(0, 9);
      calm = ($urandom_range(0, 3) == 0);
      case (kind)
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(2, 4)) begin
            step_send(edge_step(), 1'b1);
            if ($urandom_range(0, 2) == 0) step_send($urandom_range(0, deb_c), 1'b1);
            if ($urandom_range(0, 1) == 0) step_send($urandom_range(0, deb_c / 2 + 10), 1'b0);
            step_send(edge_step(), 1'b1);
          end
        end
        5, 6: begin
          repeat ($urandom_range(2, 8)) step_send($urandom_range(0, hold_c / 4 + 50), 1'b0);
        end
        7: begin
          repeat ($urandom_range(3, 8)) step_send($urandom_range(0, deb_c), 1'b1);
        end
        8: begin
          repeat ($urandom_range(1, 4)) begin
            t_now = $urandom;
            send_sample(t_now, 1'($urandom));
          end
        end
        default: begin
          t_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
          send_sample(t_now, 1'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed pass at reset settings
    calm = 1'b0;
    send_sample(32'd0, 1'b0);          // all presses equal after reset: recent
    send_sample(32'd125000, 1'b0);     // hold boundary
    send_sample(32'd125001, 1'b0);     // just past hold
    send_sample(32'd125, 1'b1);        // spacing equal to debounce: bounce
    send_sample(32'd126, 1'b1);        // first press
    send_sample(32'd251, 1'b1);        // bounce
    send_sample(32'd252, 1'b1);        // release
    send_sample(32'd400, 1'b1);
    send_sample(32'd600, 1'b1);
    send_sample(32'd800, 1'b1);        // third press inside the window
    send_sample(32'd125800, 1'b0);
    send_sample(32'd125801, 1'b0);
    send_sample(32'd126000, 1'b1);
    send_sample(32'd140000, 1'b1);
    send_sample(32'd141000, 1'b1);
    send_sample(32'd150000, 1'b1);
    send_sample(32'd160000, 1'b1);
    send_sample(32'd171250, 1'b1);     // newest minus oldest equals the window
    send_sample(32'd171400, 1'b1);
    send_sample(32'd171500, 1'b1);
    send_sample(32'hFFFF_FF00, 1'b1);  // near the top of the time range
    send_sample(32'h0000_0010, 1'b1);  // release across the wrap
    send_sample(32'hFFFF_FFFF, 1'b0);  // time runs backwards
    t_now = 32'hFFFF_FFFF;
    drain();

    // settings phases: extremes first, then reset values and random ones
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: apply_settings('0, '0, '0, '0, '1);
        1: apply_settings('1, '1, '1, '1, '0);
        2: apply_settings(DebounceRst, ClickWindowRst, HoldTicksRst, PulseRecentRst,
                          PulseIdleRst);
        default: apply_settings($urandom_range(0, 300), $urandom_range(50, 6000),
                                $urandom_range(0, 10000), 16'($urandom), 16'($urandom));
      endcase
      run_traffic((phase < 2) ? 60 : 220);
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("debounced_triple_press_detector_top regression: pass");
    end else begin
      $display("debounced_triple_press_detector_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/dtpd_pkg.sv
design/dtpd_cfg.sv
design/dtpd_cell.sv
design/debounced_triple_press_detector_top.sv
sim/dtpd_pulse_checker.sv
sim/debounced_triple_press_detector_top_tb.sv
